/* rtl/core/lpa_pkg.sv */
package lpa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int XW           = 36;
  localparam int PRESCALE     = 14;
  localparam int ZW           = 32;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_DEGEN  = 2'd2;

  localparam logic [2:0] REG_A_SX = 3'd0;
  localparam logic [2:0] REG_A_SY = 3'd1;
  localparam logic [2:0] REG_A_EX = 3'd2;
  localparam logic [2:0] REG_A_EY = 3'd3;
  localparam logic [2:0] REG_B_SX = 3'd4;
  localparam logic [2:0] REG_B_SY = 3'd5;
  localparam logic [2:0] REG_B_EX = 3'd6;
  localparam logic [2:0] REG_B_EY = 3'd7;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [15:0] DEG_K   = 16'd46080;

  typedef struct packed {
    logic            vld;
    logic [1:0]      status;
    logic signed [XW-1:0] xa;
    logic signed [XW-1:0] ya;
    logic [ZW-1:0]   za;
    logic signed [XW-1:0] xb;
    logic signed [XW-1:0] yb;
    logic [ZW-1:0]   zb;
  } cordic_stage_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/lpa_prep.sv */
module lpa_prep
  import lpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_in,
  input  logic                image_empty,
  input  logic signed [15:0]  a_sx,
  input  logic signed [15:0]  a_sy,
  input  logic signed [15:0]  a_ex,
  input  logic signed [15:0]  a_ey,
  input  logic signed [15:0]  b_sx,
  input  logic signed [15:0]  b_sy,
  input  logic signed [15:0]  b_ex,
  input  logic signed [15:0]  b_ey,
  output cordic_stage_t       st_o
);

  logic signed [16:0] dxa, dya, dxb, dyb;
  logic signed [16:0] pxa, pya, pxb, pyb;
  logic [ZW-1:0] pza, pzb;
  cordic_stage_t st_r, st_nxt;

  assign dxa = 17'(a_ex) - 17'(a_sx);
  assign dya = 17'(a_ey) - 17'(a_sy);
  assign dxb = 17'(b_ex) - 17'(b_sx);
  assign dyb = 17'(b_ey) - 17'(b_sy);

  always_comb begin
    pxa = dxa; pya = dya; pza = '0;
    if (dxa < 0) begin
      if (dya >= 0) begin
        pxa = dya; pya = -dxa; pza = 32'h40000000;
      end else begin
        pxa = -dya; pya = dxa; pza = 32'hC0000000;
      end
    end
    pxb = dxb; pyb = dyb; pzb = '0;
    if (dxb < 0) begin
      if (dyb >= 0) begin
        pxb = dyb; pyb = -dxb; pzb = 32'h40000000;
      end else begin
        pxb = -dyb; pyb = dxb; pzb = 32'hC0000000;
      end
    end
  end

  always_comb begin
    st_nxt.vld = vld_in;
    if (image_empty) begin
      st_nxt.status = ST_EMPTY;
    end else if ((dxa == 0 && dya == 0) || (dxb == 0 && dyb == 0)) begin
      st_nxt.status = ST_DEGEN;
    end else begin
      st_nxt.status = ST_OK;
    end
    st_nxt.xa = XW'(pxa) <<< PRESCALE;
    st_nxt.ya = XW'(pya) <<< PRESCALE;
    st_nxt.za = pza;
    st_nxt.xb = XW'(pxb) <<< PRESCALE;
    st_nxt.yb = XW'(pyb) <<< PRESCALE;
    st_nxt.zb = pzb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else begin
      st_r.vld <= st_nxt.vld;
    end
    st_r.status <= st_nxt.status;
    st_r.xa <= st_nxt.xa;
    st_r.ya <= st_nxt.ya;
    st_r.za <= st_nxt.za;
    st_r.xb <= st_nxt.xb;
    st_r.yb <= st_nxt.yb;
    st_r.zb <= st_nxt.zb;
  end

  assign st_o = st_r;

endmodule

/* rtl/core/lpa_cordic.sv */
module lpa_cordic
  import lpa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cordic_stage_t st_i,
  output cordic_stage_t st_o
);

  cordic_stage_t pipe_r [CORDIC_STEPS+1];

  assign pipe_r[0] = st_i;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    cordic_stage_t s, n;
    assign s = pipe_r[g];
    always_comb begin
      n = s;
      if (!s.ya[XW-1]) begin
        n.xa = s.xa + (s.ya >>> g);
        n.ya = s.ya - (s.xa >>> g);
        n.za = s.za + atan_lut(5'(g));
      end else begin
        n.xa = s.xa - (s.ya >>> g);
        n.ya = s.ya + (s.xa >>> g);
        n.za = s.za - atan_lut(5'(g));
      end
      if (!s.yb[XW-1]) begin
        n.xb = s.xb + (s.yb >>> g);
        n.yb = s.yb - (s.xb >>> g);
        n.zb = s.zb + atan_lut(5'(g));
      end else begin
        n.xb = s.xb - (s.yb >>> g);
        n.yb = s.yb + (s.xb >>> g);
        n.zb = s.zb - atan_lut(5'(g));
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[g+1].vld <= 1'b0;
      end else begin
        pipe_r[g+1].vld <= n.vld;
      end
      pipe_r[g+1].status <= n.status;
      pipe_r[g+1].xa <= n.xa;
      pipe_r[g+1].ya <= n.ya;
      pipe_r[g+1].za <= n.za;
      pipe_r[g+1].xb <= n.xb;
      pipe_r[g+1].yb <= n.yb;
      pipe_r[g+1].zb <= n.zb;
    end
  end

  assign st_o = pipe_r[CORDIC_STEPS];

endmodule

/* rtl/core/lpa_scale.sv */
module lpa_scale
  import lpa_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cordic_stage_t st_i,
  output logic          vld_o,
  output logic          ok_o,
  output logic [1:0]    status_o,
  output logic [15:0]   deg_o,
  output logic [15:0]   rad_o
);

  logic [ZW-1:0] d;
  logic [ZW:0]   m_nxt, m_r;
  logic          v1_r, v2_r;
  logic [1:0]    s1_r, s2_r;
  logic [64:0]   prad_r;
  logic [48:0]   pdeg_r;
  logic [64:0]   rsum;
  logic [48:0]   dsum;

  assign d = st_i.za - st_i.zb;
  assign m_nxt = d[ZW-1] ? ((ZW+1)'(1) << ZW) - {1'b0, d} : {1'b0, d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= st_i.vld;
      v2_r <= v1_r;
    end
    s1_r <= st_i.status;
    m_r  <= m_nxt;
    s2_r <= s1_r;
    prad_r <= 65'(m_r) * 65'(PI_Q30);
    pdeg_r <= 49'(m_r) * 49'(DEG_K);
  end

  assign rsum = prad_r + (65'(1) << 46);
  assign dsum = pdeg_r + (49'(1) << 30);

  assign vld_o    = v2_r;
  assign ok_o     = (s2_r == ST_OK);
  assign status_o = s2_r;
  assign deg_o    = (s2_r == ST_OK) ? dsum[46:31] : 16'd0;
  assign rad_o    = (s2_r == ST_OK) ? rsum[62:47] : 16'd0;

`ifndef SYNTH
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    vld_o |-> (status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_DEGEN))
    else $error("bad status");
  a_vld_delay: assert property (@(posedge clk) disable iff (!rst_n)
    st_i.vld |-> ##2 vld_o) else $error("valid lost");
  a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_o && !ok_o) |-> (deg_o == 16'd0 && rad_o == 16'd0)) else $error("angle on error");
`endif

endmodule

/* rtl/core/line_pair_angle.sv */
// line_pair_angle: unsigned angle between two configured line segments.
// Config: write cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//   Indexes 0..7 hold line A start x/y, end x/y, line B start x/y, end x/y
//   (signed Q12.4). Other indexes are ignored. Write only while idle.
// Input: an item is taken when start is high and busy is low; busy is
//   always low, so one item may enter every cycle. in_image_empty rides along.
// Output: out_valid strobes for one cycle with out_ok, out_status,
//   out_angle_degrees (Q8.8) and out_angle_radians (Q2.14).
// Pipeline from accept to strobe: 1 prep stage, 16 CORDIC
//   stages, 2 scaling stages. Throughput: one item per cycle, set by the
//   fully pipelined CORDIC with both lines in parallel lanes.
// Reset: synchronous active-low rst_n clears all valid bits and the
//   coordinate registers to zero; items in flight are dropped.
// The receiver cannot stall; results are shown once and not held.
module line_pair_angle
  import lpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_image_empty,
  output logic        out_valid,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic [15:0] out_angle_degrees,
  output logic [15:0] out_angle_radians,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic signed [15:0] regs_r [8];
  cordic_stage_t s_prep, s_cord;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
    end else if (cfg_valid) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  lpa_prep u_prep (
    .clk, .rst_n,
    .vld_in(start && !busy),
    .image_empty(in_image_empty),
    .a_sx(regs_r[REG_A_SX]), .a_sy(regs_r[REG_A_SY]),
    .a_ex(regs_r[REG_A_EX]), .a_ey(regs_r[REG_A_EY]),
    .b_sx(regs_r[REG_B_SX]), .b_sy(regs_r[REG_B_SY]),
    .b_ex(regs_r[REG_B_EX]), .b_ey(regs_r[REG_B_EY]),
    .st_o(s_prep)
  );

  lpa_cordic u_cordic (.clk, .rst_n, .st_i(s_prep), .st_o(s_cord));

  lpa_scale u_scale (
    .clk, .rst_n, .st_i(s_cord),
    .vld_o(out_valid), .ok_o(out_ok), .status_o(out_status),
    .deg_o(out_angle_degrees), .rad_o(out_angle_radians)
  );

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import lpa_pkg::*;

  typedef struct {
    logic        ok;
    logic [1:0]  status;
    logic [15:0] deg;
    logic [15:0] rad;
  } angle_t;

  class angle_scoreboard;
    logic [15:0] coord[8];
    angle_t      pending[$];
    int          mismatches;
    int          failures;

    function new();
      foreach (coord[i]) coord[i] = '0;
      mismatches = 0;
      failures = 0;
    endfunction

    function automatic logic [31:0] heading(longint dx, longint dy);
      longint x, y, t;
      logic [31:0] z;
      z = '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          x = dy; y = -dx; z = 32'h4000_0000;
        end else begin
          x = -dy; y = dx; z = 32'hC000_0000;
        end
      end else begin
        x = dx; y = dy;
      end
      x = x * (longint'(1) << PRESCALE);
      y = y * (longint'(1) << PRESCALE);
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + atan_lut(5'(i));
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - atan_lut(5'(i));
        end
        x = t;
      end
      return z;
    endfunction

    function void note(logic empty);
      angle_t e;
      longint dxa, dya, dxb, dyb;
      logic [31:0] d;
      logic [63:0] m;
      e = '{1'b0, ST_OK, 16'd0, 16'd0};
      dxa = longint'($signed(coord[REG_A_EX])) - longint'($signed(coord[REG_A_SX]));
      dya = longint'($signed(coord[REG_A_EY])) - longint'($signed(coord[REG_A_SY]));
      dxb = longint'($signed(coord[REG_B_EX])) - longint'($signed(coord[REG_B_SX]));
      dyb = longint'($signed(coord[REG_B_EY])) - longint'($signed(coord[REG_B_SY]));
      if (empty) begin
        e.status = ST_EMPTY;
      end else if ((dxa == 0 && dya == 0) || (dxb == 0 && dyb == 0)) begin
        e.status = ST_DEGEN;
      end else begin
        d = heading(dxa, dya) - heading(dxb, dyb);
        if (d[31]) m = 64'h1_0000_0000 - 64'(d);
        else m = 64'(d);
        e.ok = 1'b1;
        e.deg = 16'((m * 64'd46080 + (64'd1 << 30)) >> 31);
        e.rad = 16'((m * 64'(PI_Q30) + (64'd1 << 46)) >> 47);
      end
      pending.push_back(e);
    endfunction

    function void check(angle_t got);
      angle_t e;
      if (pending.size() == 0) begin
        failures++;
        $display("unexpected result ok=%0d status=%0d", got.ok, got.status);
        return;
      end
      e = pending.pop_front();
      if (got.ok !== e.ok || got.status !== e.status || got.deg !== e.deg ||
          got.rad !== e.rad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ok=%0d st=%0d deg=%0d rad=%0d, %s",
                   e.ok, e.status, e.deg, e.rad,
                   $sformatf("got ok=%0d st=%0d deg=%0d rad=%0d",
                             got.ok, got.status, got.deg, got.rad));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_image_empty = 1'b0;
  logic        out_valid;
  logic        out_ok;
  logic [1:0]  out_status;
  logic [15:0] out_angle_degrees;
  logic [15:0] out_angle_radians;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  angle_scoreboard sb = new();
  int cycles = 0;

  line_pair_angle u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid)
      sb.check('{out_ok, out_status, out_angle_degrees, out_angle_radians});

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic empty);
    int g;
    start <= 1'b1;
    in_image_empty <= empty;
    do @(posedge clk); while (busy);
    sb.note(empty);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_coord(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.coord[idx] = val;
  endtask

  task automatic set_lines(logic [15:0] v[8]);
    drain();
    for (int i = 0; i < 8; i++) write_coord(3'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64) - 32);
      default: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  initial begin
    logic [15:0] v[8];
    int mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coordinates: both lines zero length
    send_item(1'b0);
    send_item(1'b1);

    v = '{16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0010};
    set_lines(v);
    send_item(1'b0);
    send_item(1'b1);
    v = '{16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h0000, 16'hFFF0, 16'h0000};
    set_lines(v);
    send_item(1'b0);
    v = '{16'h0000, 16'h0000, 16'hFFF0, 16'hFFF0, 16'h0000, 16'h0000, 16'hFFF0, 16'h0010};
    set_lines(v);
    send_item(1'b0);
    v = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000};
    set_lines(v);
    send_item(1'b0);
    send_item(1'b0);
    v = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF};
    set_lines(v);
    send_item(1'b0);
    v = '{16'h1234, 16'h0042, 16'h1234, 16'h0042, 16'h0000, 16'h0000, 16'h0001, 16'h0000};
    set_lines(v);
    send_item(1'b0);
    v = '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    set_lines(v);
    send_item(1'b0);
    send_item(1'b1);
    v = '{16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000, 16'h0000, 16'h0010, 16'h0000};
    set_lines(v);
    send_item(1'b0);

    for (int p = 0; p < 40; p++) begin
      mode = $urandom_range(0, 2);
      foreach (v[i]) v[i] = rand_coord($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : mode);
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) begin
          v[REG_A_EX] = v[REG_A_SX]; v[REG_A_EY] = v[REG_A_SY];
        end else begin
          v[REG_B_EX] = v[REG_B_SX]; v[REG_B_EY] = v[REG_B_SY];
        end
      end
      set_lines(v);
      repeat (25) send_item($urandom_range(0, 9) == 0);
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.failures == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
